// ----- rtl/core/csli_pkg.sv -----
// Shared types, codes and constants of the cached segment linear interpolator.
package csli_pkg;

    // Fixed widths of the item fields on the ports
    localparam int FIELD_TIME_BITS  = 48;
    localparam int FIELD_COORD_BITS = 32;
    localparam int FRAC_BITS        = 32;
    localparam int DIV_STEPS        = 32;
    localparam int DIV_CNT_BITS     = 5;

    // Operation codes
    localparam logic [1:0] OP_QUERY = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_SPARE = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_RANGE   = 2'd1;
    localparam logic [1:0] ST_REFUSED = 2'd2;

    typedef struct packed {
        logic [1:0]         operation;
        logic [47:0]        sample_time;
        logic signed [31:0] coord_in_0;
        logic signed [31:0] coord_in_1;
        logic signed [31:0] coord_in_2;
        logic signed [31:0] coord_in_3;
        logic signed [31:0] coord_in_4;
        logic signed [31:0] coord_in_5;
    } t_item;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] coord_out_0;
        logic signed [31:0] coord_out_1;
        logic signed [31:0] coord_out_2;
        logic signed [31:0] coord_out_3;
        logic signed [31:0] coord_out_4;
        logic signed [31:0] coord_out_5;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_LOAD_CHK,
        S_WALK_A,
        S_WALK_B,
        S_WALK_C,
        S_HIT_RD,
        S_HIT_CAP,
        S_DIV,
        S_ROW_P,
        S_ROW_N,
        S_ROW_W,
        S_MUL,
        S_ACC,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        TS_SEG,
        TS_NEXT,
        TS_LAST
    } t_time_sel;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       accept;
        logic       set_status;
        logic [1:0] status;
        logic       time_rd;
        t_time_sel  time_sel;
        logic       load_write;
        logic       count_clear;
        logic       seg_clear;
        logic       seg_inc;
        logic       seg_dec;
        logic       set_a;
        logic       a_next;
        logic       cap_tp;
        logic       div_init;
        logic       div_step;
        logic       row_rd;
        logic       row_next;
        logic       cap_p;
        logic       cap_n;
        logic       hit_out;
        logic       mul;
        logic       acc;
    } t_cmd;

    // Status flags from the datapath to the controller
    typedef struct packed {
        logic [1:0] op;
        logic       count_zero;
        logic       count_full;
        logic       seg_bad;
        logic       seg_zero;
        logic       has_next;
        logic       t_le_last;
        logic       t_lt_tp;
        logic       t_gt_tn;
        logic       t_eq_tp;
        logic       t_eq_tn;
        logic       div_last;
        logic       k_last;
    } t_stat;

endpackage

// ----- rtl/core/csli_ctrl.sv -----
// Controller state machine: sequences loads, clears, segment walk and interpolation.
module csli_ctrl
    import csli_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy,
    output logic  o_done
);

    t_state r_state;
    t_state n_state;

    // Hold the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Pick the next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                case (i_stat.op)
                    OP_LOAD: begin
                        if (i_stat.count_full || i_stat.count_zero) n_state = S_DONE;
                        else n_state = S_LOAD_CHK;
                    end
                    OP_QUERY: begin
                        if (i_stat.count_zero || i_stat.seg_bad) n_state = S_DONE;
                        else n_state = S_WALK_A;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_LOAD_CHK: n_state = S_DONE;
            S_WALK_A:   n_state = S_WALK_B;
            S_WALK_B:   n_state = S_WALK_C;
            S_WALK_C: begin
                if (i_stat.has_next) begin
                    if (i_stat.t_lt_tp) begin
                        n_state = i_stat.seg_zero ? S_DONE : S_WALK_A;
                    end else if (i_stat.t_gt_tn) begin
                        n_state = S_WALK_A;
                    end else if (i_stat.t_eq_tp || i_stat.t_eq_tn) begin
                        n_state = S_HIT_RD;
                    end else begin
                        n_state = S_DIV;
                    end
                end else begin
                    if (i_stat.t_eq_tp) n_state = S_HIT_RD;
                    else if (!i_stat.t_lt_tp || i_stat.seg_zero) n_state = S_DONE;
                    else n_state = S_WALK_A;
                end
            end
            S_HIT_RD:  n_state = S_HIT_CAP;
            S_HIT_CAP: n_state = S_DONE;
            S_DIV: begin
                if (i_stat.div_last) n_state = S_ROW_P;
            end
            S_ROW_P: n_state = S_ROW_N;
            S_ROW_N: n_state = S_ROW_W;
            S_ROW_W: n_state = S_MUL;
            S_MUL:   n_state = S_ACC;
            S_ACC:   n_state = i_stat.k_last ? S_DONE : S_MUL;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Drive the datapath commands
    always_comb begin
        o_cmd          = '0;
        o_cmd.time_sel = TS_SEG;
        o_cmd.status   = ST_OK;
        case (r_state)
            S_IDLE: o_cmd.accept = i_start;
            S_DISPATCH: begin
                case (i_stat.op)
                    OP_LOAD: begin
                        if (i_stat.count_full) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_REFUSED;
                        end else if (i_stat.count_zero) begin
                            o_cmd.load_write = 1'b1;
                        end else begin
                            o_cmd.time_rd  = 1'b1;
                            o_cmd.time_sel = TS_LAST;
                        end
                    end
                    OP_CLEAR: begin
                        o_cmd.count_clear = 1'b1;
                        o_cmd.seg_clear   = 1'b1;
                    end
                    OP_QUERY: begin
                        if (i_stat.count_zero || i_stat.seg_bad) begin
                            o_cmd.seg_clear  = 1'b1;
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_RANGE;
                        end
                    end
                    default: ;
                endcase
            end
            S_LOAD_CHK: begin
                if (i_stat.t_le_last) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_REFUSED;
                end else begin
                    o_cmd.load_write = 1'b1;
                end
            end
            S_WALK_A: begin
                o_cmd.time_rd  = 1'b1;
                o_cmd.time_sel = TS_SEG;
            end
            S_WALK_B: begin
                o_cmd.cap_tp   = 1'b1;
                o_cmd.time_rd  = 1'b1;
                o_cmd.time_sel = TS_NEXT;
            end
            S_WALK_C: begin
                if (i_stat.has_next) begin
                    if (i_stat.t_lt_tp) begin
                        if (i_stat.seg_zero) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_RANGE;
                        end else begin
                            o_cmd.seg_dec = 1'b1;
                        end
                    end else if (i_stat.t_gt_tn) begin
                        o_cmd.seg_inc = 1'b1;
                    end else if (i_stat.t_eq_tp) begin
                        o_cmd.set_a = 1'b1;
                    end else if (i_stat.t_eq_tn) begin
                        o_cmd.set_a  = 1'b1;
                        o_cmd.a_next = 1'b1;
                    end else begin
                        o_cmd.set_a    = 1'b1;
                        o_cmd.div_init = 1'b1;
                    end
                end else begin
                    if (i_stat.t_eq_tp) begin
                        o_cmd.set_a = 1'b1;
                    end else if (!i_stat.t_lt_tp || i_stat.seg_zero) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_RANGE;
                    end else begin
                        o_cmd.seg_dec = 1'b1;
                    end
                end
            end
            S_HIT_RD:  o_cmd.row_rd = 1'b1;
            S_HIT_CAP: o_cmd.hit_out = 1'b1;
            S_DIV:     o_cmd.div_step = 1'b1;
            S_ROW_P:   o_cmd.row_rd = 1'b1;
            S_ROW_N: begin
                o_cmd.cap_p    = 1'b1;
                o_cmd.row_rd   = 1'b1;
                o_cmd.row_next = 1'b1;
            end
            S_ROW_W: o_cmd.cap_n = 1'b1;
            S_MUL:   o_cmd.mul = 1'b1;
            S_ACC:   o_cmd.acc = 1'b1;
            default: ;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

endmodule

// ----- rtl/core/csli_dp.sv -----
// Datapath: sample memories, segment index, fraction divider and coordinate blend.
module csli_dp
    import csli_pkg::*;
#(
    parameter int TABLE_DEPTH = 256,
    parameter int COORD_COUNT = 6,
    parameter int COORD_BITS  = 32,
    parameter int TIME_BITS   = 48
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_item   i_item,
    input  t_cmd    i_cmd,
    output t_stat   o_stat,
    output t_result o_result
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int KW = (COORD_COUNT > 1) ? $clog2(COORD_COUNT) : 1;
    localparam int RW = COORD_COUNT * COORD_BITS;
    localparam int DW = COORD_BITS + 1;
    localparam int PW = DW + FRAC_BITS + 1;

    // Sample storage
    logic [TIME_BITS-1:0] r_times [TABLE_DEPTH];
    logic [RW-1:0]        r_rows  [TABLE_DEPTH];

    logic [1:0]                   r_op;
    logic [TIME_BITS-1:0]         r_t;
    logic [RW-1:0]                r_row_in;
    logic [CW-1:0]                r_count;
    logic [AW-1:0]                r_seg;
    logic [AW-1:0]                r_a;
    logic [TIME_BITS-1:0]         r_tp;
    logic [TIME_BITS-1:0]         r_time_rd;
    logic [RW-1:0]                r_row_rd;
    logic signed [COORD_BITS-1:0] r_p    [COORD_COUNT];
    logic signed [DW-1:0]         r_diff [COORD_COUNT];
    logic [TIME_BITS:0]           r_rem;
    logic [TIME_BITS-1:0]         r_den;
    logic [FRAC_BITS-1:0]         r_ratio;
    logic [DIV_CNT_BITS-1:0]      r_divcnt;
    logic [KW-1:0]                r_k;
    logic signed [PW-1:0]         r_prod;
    logic [1:0]                   r_status;
    logic [FIELD_COORD_BITS-1:0]  r_res  [COORD_COUNT];

    logic [FIELD_COORD_BITS-1:0] w_cin [6];
    logic [RW-1:0]               w_row_in;
    logic [63:0]                 w_t_ext;
    logic [AW-1:0]               w_time_addr;
    logic [CW-1:0]               w_last;
    logic [AW-1:0]               w_row_addr;
    logic [TIME_BITS:0]          w_sh;
    logic [TIME_BITS:0]          w_sub;
    logic signed [DW+1:0]        w_step;
    logic signed [DW+1:0]        w_sum;

    assign w_cin[0] = i_item.coord_in_0;
    assign w_cin[1] = i_item.coord_in_1;
    assign w_cin[2] = i_item.coord_in_2;
    assign w_cin[3] = i_item.coord_in_3;
    assign w_cin[4] = i_item.coord_in_4;
    assign w_cin[5] = i_item.coord_in_5;
    assign w_t_ext  = 64'(i_item.sample_time);

    // Pack the incoming coordinates into one row
    for (genvar g = 0; g < COORD_COUNT; g++) begin : g_pack
        logic [63:0] w_ext;
        assign w_ext = 64'(w_cin[g]);
        assign w_row_in[g*COORD_BITS +: COORD_BITS] = w_ext[COORD_BITS-1:0];
    end

    // Select the read addresses
    assign w_last = r_count - CW'(1);
    always_comb begin
        case (i_cmd.time_sel)
            TS_NEXT: w_time_addr = r_seg + AW'(1);
            TS_LAST: w_time_addr = w_last[AW-1:0];
            default: w_time_addr = r_seg;
        endcase
    end
    assign w_row_addr = i_cmd.row_next ? (r_a + AW'(1)) : r_a;

    // Write and read the sample memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_write) begin
            r_times[r_count[AW-1:0]] <= r_t;
            r_rows[r_count[AW-1:0]]  <= r_row_in;
        end
        if (i_cmd.time_rd) r_time_rd <= r_times[w_time_addr];
        if (i_cmd.row_rd)  r_row_rd  <= r_rows[w_row_addr];
    end

    // Track table fill and the cached segment
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_seg   <= '0;
        end else begin
            if (i_cmd.count_clear) r_count <= '0;
            else if (i_cmd.load_write) r_count <= r_count + CW'(1);
            if (i_cmd.seg_clear) r_seg <= '0;
            else if (i_cmd.seg_inc) r_seg <= r_seg + AW'(1);
            else if (i_cmd.seg_dec) r_seg <= r_seg - AW'(1);
        end
    end

    // Latch the item and the segment endpoints
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op     <= i_item.operation;
            r_t      <= w_t_ext[TIME_BITS-1:0];
            r_row_in <= w_row_in;
        end
        if (i_cmd.cap_tp) r_tp <= r_time_rd;
        if (i_cmd.set_a) r_a <= i_cmd.a_next ? (r_seg + AW'(1)) : r_seg;
    end

    // Restoring division for the 32-bit fraction, one quotient bit per cycle
    assign w_sh  = {r_rem[TIME_BITS-1:0], 1'b0};
    assign w_sub = w_sh - {1'b0, r_den};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_divcnt <= '0;
        end else if (i_cmd.div_init) begin
            r_divcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_divcnt <= r_divcnt + DIV_CNT_BITS'(1);
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_rem   <= {1'b0, r_t - r_tp};
            r_den   <= r_time_rd - r_tp;
            r_ratio <= '0;
        end else if (i_cmd.div_step) begin
            if (w_sh >= {1'b0, r_den}) begin
                r_rem   <= w_sub;
                r_ratio <= {r_ratio[FRAC_BITS-2:0], 1'b1};
            end else begin
                r_rem   <= w_sh;
                r_ratio <= {r_ratio[FRAC_BITS-2:0], 1'b0};
            end
        end
    end

    // Capture endpoint rows and blend one coordinate at a time, a multiply then an accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0;
        end else if (i_cmd.cap_n) begin
            r_k <= '0;
        end else if (i_cmd.acc) begin
            r_k <= r_k + KW'(1);
        end
    end
    for (genvar g = 0; g < COORD_COUNT; g++) begin : g_row
        logic signed [COORD_BITS-1:0] w_c;
        assign w_c = $signed(r_row_rd[g*COORD_BITS +: COORD_BITS]);
        always_ff @(posedge i_clk) begin
            if (i_cmd.cap_p) r_p[g] <= w_c;
            if (i_cmd.cap_n) r_diff[g] <= DW'(w_c) - DW'(r_p[g]);
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) r_prod <= PW'(r_diff[r_k]) * PW'($signed({1'b0, r_ratio}));
    end
    assign w_step = (DW + 2)'($signed(r_prod[PW-1:FRAC_BITS]));
    assign w_sum  = (DW + 2)'(r_p[r_k]) + w_step;

    // Build the result
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_status <= ST_OK;
        end else if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
    end
    for (genvar g = 0; g < COORD_COUNT; g++) begin : g_res
        logic [63:0] w_hit;
        logic [63:0] w_blend;
        assign w_hit   = 64'(r_row_rd[g*COORD_BITS +: COORD_BITS]);
        assign w_blend = 64'(w_sum[COORD_BITS-1:0]);
        always_ff @(posedge i_clk) begin
            if (i_cmd.accept) begin
                r_res[g] <= '0;
            end else if (i_cmd.hit_out) begin
                r_res[g] <= w_hit[FIELD_COORD_BITS-1:0];
            end else if (i_cmd.acc && (r_k == KW'(g))) begin
                r_res[g] <= w_blend[FIELD_COORD_BITS-1:0];
            end
        end
    end

    logic [FIELD_COORD_BITS-1:0] w_out [6];
    for (genvar g = 0; g < 6; g++) begin : g_out
        if (g < COORD_COUNT) begin : g_used
            assign w_out[g] = r_res[g];
        end else begin : g_zero
            assign w_out[g] = '0;
        end
    end

    assign o_result.status      = r_status;
    assign o_result.coord_out_0 = w_out[0];
    assign o_result.coord_out_1 = w_out[1];
    assign o_result.coord_out_2 = w_out[2];
    assign o_result.coord_out_3 = w_out[3];
    assign o_result.coord_out_4 = w_out[4];
    assign o_result.coord_out_5 = w_out[5];

    // Report status flags
    assign o_stat.op         = r_op;
    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.count_full = (r_count == CW'(TABLE_DEPTH));
    assign o_stat.seg_bad    = ((CW + 1)'(r_seg) >= (CW + 1)'(r_count));
    assign o_stat.seg_zero   = (r_seg == '0);
    assign o_stat.has_next   = ((CW + 1)'(r_seg) + (CW + 1)'(1) < (CW + 1)'(r_count));
    assign o_stat.t_le_last  = (r_t <= r_time_rd);
    assign o_stat.t_lt_tp    = (r_t < r_tp);
    assign o_stat.t_gt_tn    = (r_t > r_time_rd);
    assign o_stat.t_eq_tp    = (r_t == r_tp);
    assign o_stat.t_eq_tn    = (r_t == r_time_rd);
    assign o_stat.div_last   = (r_divcnt == DIV_CNT_BITS'(DIV_STEPS - 1));
    assign o_stat.k_last     = (r_k == KW'(COORD_COUNT - 1));

endmodule

// ----- rtl/core/cached_segment_linear_interpolator_core.sv -----
// Top level of the cached segment linear interpolator: controller plus datapath.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------
//  item in  | start high, busy low | i_item   (t_item)
//  result   | o_done, one cycle    | o_result (t_result)
//
// Load, clear and an empty or unused query skip the walk. A query walks one
// segment at a time, reading both segment times, then reads out the row on
// an exact hit, or runs the divider for the 32-bit fraction, reads both
// endpoint rows and blends one coordinate at a time. The single read port of
// each sample memory and the one-bit-per-cycle divider set the pace. Reset
// empties the table at once; busy stays high until the result strobe is shown.
module cached_segment_linear_interpolator_core
    import csli_pkg::*;
#(
    parameter int TABLE_DEPTH = 256,
    parameter int COORD_COUNT = 6,
    parameter int COORD_BITS  = 32,
    parameter int TIME_BITS   = 48
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_item   i_item,
    output logic    o_done,
    output t_result o_result
);

    t_cmd  w_cmd;
    t_stat w_stat;

    // Sequence the work
    csli_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    // Store samples and compute
    csli_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COORD_COUNT (COORD_COUNT),
        .COORD_BITS  (COORD_BITS),
        .TIME_BITS   (TIME_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (w_cmd),
        .o_stat   (w_stat),
        .o_result (o_result)
    );

endmodule

// ----- rtl/core/csli_checker.sv -----
// Port checker for the interpolator top level, with its bind.
module csli_port_checker
    import csli_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input logic    busy,
    input logic    o_done,
    input t_result o_result
);

    // An accepted item makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting an item");

    // A result only shows while the item is still held
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result strobe while idle");

    // One result per item
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe repeated");

    // Failed items carry zero coordinates
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status != ST_OK)) |->
        ((o_result.coord_out_0 == '0) && (o_result.coord_out_1 == '0) &&
         (o_result.coord_out_2 == '0) && (o_result.coord_out_3 == '0) &&
         (o_result.coord_out_4 == '0) && (o_result.coord_out_5 == '0)))
        else $error("nonzero coordinates on a failed item");

    // Status is a defined code
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ((o_result.status == ST_OK) || (o_result.status == ST_RANGE) ||
                    (o_result.status == ST_REFUSED)))
        else $error("undefined status code");

endmodule

bind cached_segment_linear_interpolator_core csli_port_checker u_csli_port_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);
